### design/plbe_pkg.sv
// shared types and constants for the price level book engine
package plbe_pkg;

    localparam int LEVEL_SLOTS_DEF = 1024;
    localparam int ORD_W           = 20;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_W     = 2;

    localparam logic [31:0]      QTY_MAX = 32'hFFFF_FFFF;
    localparam logic [ORD_W-1:0] ORD_MAX = {ORD_W{1'b1}};

    // request type codes
    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_REDUCE = 1'b1;

    // side codes
    localparam logic SIDE_SELL = 1'b0;
    localparam logic SIDE_BUY  = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic        buy_side;
        logic [31:0] order_price;
        logic [31:0] share_count;
        logic [7:0]  order_epoch;
        logic        order_done;
    } req_item_t;

    typedef struct packed {
        logic        placed;
        logic [9:0]  level_slot;
        logic [7:0]  current_epoch;
        logic        applied;
        logic        best_buy_valid;
        logic [31:0] best_buy_price;
        logic [31:0] best_buy_quantity;
        logic        best_sell_valid;
        logic [31:0] best_sell_price;
        logic [31:0] best_sell_quantity;
    } rsp_item_t;

    // classified request with the candidate window bases worked out up front
    typedef struct packed {
        req_item_t   item;
        logic [31:0] half_base;
        logic [31:0] quarter_base;
        logic [31:0] upper_base;
    } cmd_t;

    typedef struct packed {
        logic [31:0]      qty;
        logic [ORD_W-1:0] ord;
    } level_t;

endpackage

### design/plbe_queue.sv
// command queue between the front and back parts
module plbe_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  plbe_pkg::cmd_t push_data,
    input  logic          pop,
    output plbe_pkg::cmd_t pop_data,
    output logic          full,
    output logic          empty
);

    plbe_pkg::cmd_t entry_reg [plbe_pkg::QUEUE_DEPTH];
    logic [plbe_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [plbe_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [plbe_pkg::QUEUE_PTR_W:0]   count_reg, count_next;

    assign full     = (count_reg == (plbe_pkg::QUEUE_PTR_W+1)'(plbe_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/plbe_front.sv
// front part: takes requests and works out the candidate window bases
module plbe_front #(
    parameter int LEVEL_SLOTS = plbe_pkg::LEVEL_SLOTS_DEF
) (
    input  logic                req_valid,
    output logic                req_stall,
    input  plbe_pkg::req_item_t req,
    input  logic                queue_full,
    input  logic                init_busy,
    output logic                push,
    output plbe_pkg::cmd_t      cmd
);

    localparam logic [31:0] SLOT_H  = 32'(LEVEL_SLOTS / 2);
    localparam logic [31:0] SLOT_Q  = 32'(LEVEL_SLOTS / 4);
    localparam logic [31:0] SLOT_3Q = 32'(LEVEL_SLOTS * 3 / 4);

    assign req_stall = queue_full | init_busy;
    assign push      = req_valid & ~req_stall;

    // window base candidates, clamped at zero
    always_comb
    begin
        cmd.item         = req;
        cmd.half_base    = (req.order_price >= SLOT_H)  ? req.order_price - SLOT_H  : '0;
        cmd.quarter_base = (req.order_price >= SLOT_Q)  ? req.order_price - SLOT_Q  : '0;
        cmd.upper_base   = (req.order_price >= SLOT_3Q) ? req.order_price - SLOT_3Q : '0;
    end

endmodule

### design/plbe_level_ram.sv
// one side's level memory, one write and one registered read port
module plbe_level_ram #(
    parameter int LEVEL_SLOTS = plbe_pkg::LEVEL_SLOTS_DEF,
    parameter int SLOT_W      = $clog2(plbe_pkg::LEVEL_SLOTS_DEF)
) (
    input  logic                clk,
    input  logic                we,
    input  logic [SLOT_W-1:0]   waddr,
    input  plbe_pkg::level_t    wdata,
    input  logic                re,
    input  logic [SLOT_W-1:0]   raddr,
    output plbe_pkg::level_t    rdata
);

    plbe_pkg::level_t mem [LEVEL_SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/plbe_back.sv
// back part: sequencer that carries out adds, reduces, window shifts and best walks
module plbe_back #(
    parameter int LEVEL_SLOTS = plbe_pkg::LEVEL_SLOTS_DEF,
    parameter int SLOT_W      = $clog2(plbe_pkg::LEVEL_SLOTS_DEF)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                queue_empty,
    input  plbe_pkg::cmd_t      queue_data,
    output logic                queue_pop,
    output logic                init_busy,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output plbe_pkg::rsp_item_t rsp
);

    localparam logic [3:0] S_INIT = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_ADD0 = 4'd2;
    localparam logic [3:0] S_ADD1 = 4'd3;
    localparam logic [3:0] S_CLR  = 4'd4;
    localparam logic [3:0] S_WRD  = 4'd5;
    localparam logic [3:0] S_WCHK = 4'd6;
    localparam logic [3:0] S_ARD  = 4'd7;
    localparam logic [3:0] S_AWR  = 4'd8;
    localparam logic [3:0] S_BRD  = 4'd9;
    localparam logic [3:0] S_BCHK = 4'd10;
    localparam logic [3:0] S_R0   = 4'd11;
    localparam logic [3:0] S_RRD  = 4'd12;
    localparam logic [3:0] S_RWR  = 4'd13;
    localparam logic [3:0] S_ORD  = 4'd14;
    localparam logic [3:0] S_OCAP = 4'd15;

    localparam logic [SLOT_W:0]   SLOTS_EXT = (SLOT_W+1)'(LEVEL_SLOTS);
    localparam logic [SLOT_W-1:0] TOP_SLOT  = SLOT_W'(LEVEL_SLOTS - 1);
    localparam logic [31:0]       SLOTS32   = 32'(LEVEL_SLOTS);

    logic [3:0]           state_reg, state_next;
    plbe_pkg::cmd_t       cur_reg, cur_next;
    logic [31:0]          base_reg [2];
    logic [31:0]          base_next [2];
    logic [SLOT_W-1:0]    best_reg [2];
    logic [SLOT_W-1:0]    best_next [2];
    logic [SLOT_W-1:0]    rot_reg [2];
    logic [SLOT_W-1:0]    rot_next [2];
    logic                 started_reg [2];
    logic                 started_next [2];
    logic [7:0]           epoch_reg [2];
    logic [7:0]           epoch_next [2];
    logic [SLOT_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [SLOT_W-1:0]    clr_end_reg, clr_end_next;
    logic [SLOT_W-1:0]    idx_reg, idx_next;
    logic                 placed_reg, placed_next;
    logic                 applied_reg, applied_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    plbe_pkg::rsp_item_t  rsp_reg, rsp_next;

    logic                 re [2];
    logic [SLOT_W-1:0]    raddr [2];
    plbe_pkg::level_t     rdata [2];
    logic                 we [2];
    logic [SLOT_W-1:0]    waddr [2];
    plbe_pkg::level_t     wdata;

    logic                 sd;
    logic                 out_load;

    // logical slot to ring position
    function automatic logic [SLOT_W-1:0] to_phys(input logic [SLOT_W-1:0] lg,
                                                  input logic [SLOT_W-1:0] rot);
        logic [SLOT_W:0] sum;
        sum = {1'b0, lg} + {1'b0, rot};
        if (sum >= SLOTS_EXT)
        begin
            sum = sum - SLOTS_EXT;
        end
        return sum[SLOT_W-1:0];
    endfunction

    assign sd        = cur_reg.item.buy_side;
    assign init_busy = (state_reg == S_INIT);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // sequencer
    always_comb
    begin
        logic [31:0]     cur_base;
        logic [31:0]     diff;
        logic [31:0]     nb;
        logic [31:0]     shv;
        logic            below;
        logic            above;
        logic            in_win;
        logic [SLOT_W-1:0] sh;
        logic [SLOT_W:0] rsum;
        logic [SLOT_W:0] bsum;
        logic [32:0]     qsum;
        plbe_pkg::level_t ent;
        logic [31:0]     qbuy;
        logic [31:0]     qsell;

        state_next     = state_reg;
        cur_next       = cur_reg;
        base_next      = base_reg;
        best_next      = best_reg;
        rot_next       = rot_reg;
        started_next   = started_reg;
        epoch_next     = epoch_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_end_next   = clr_end_reg;
        idx_next       = idx_reg;
        placed_next    = placed_reg;
        applied_next   = applied_reg;
        rsp_next       = rsp_reg;
        queue_pop      = 1'b0;
        out_load       = 1'b0;
        re[0]          = 1'b0;
        re[1]          = 1'b0;
        raddr[0]       = to_phys(best_reg[0], rot_reg[0]);
        raddr[1]       = to_phys(best_reg[1], rot_reg[1]);
        we[0]          = 1'b0;
        we[1]          = 1'b0;
        waddr[0]       = to_phys(clr_cnt_reg, rot_reg[0]);
        waddr[1]       = to_phys(clr_cnt_reg, rot_reg[1]);
        wdata          = '0;

        // window position of the current price
        cur_base = base_reg[sd];
        below    = (cur_reg.item.order_price < cur_base);
        diff     = cur_reg.item.order_price - cur_base;
        above    = !below && (diff >= SLOTS32);
        in_win   = !below && !above;
        nb       = below ? cur_reg.quarter_base : cur_reg.upper_base;
        shv      = below ? cur_base - nb : nb - cur_base;
        sh       = shv[SLOT_W-1:0];
        rsum     = '0;
        bsum     = '0;
        qsum     = '0;
        ent      = rdata[sd];
        qbuy     = rdata[1].qty;
        qsell    = rdata[0].qty;

        case (state_reg)
            S_INIT:
            begin
                // clearing pass over both sides after reset
                we[0]    = 1'b1;
                we[1]    = 1'b1;
                waddr[0] = clr_cnt_reg;
                waddr[1] = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == TOP_SLOT)
                begin
                    clr_cnt_next = '0;
                    state_next   = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!queue_empty)
                begin
                    queue_pop    = 1'b1;
                    cur_next     = queue_data;
                    placed_next  = 1'b0;
                    applied_next = 1'b0;
                    state_next   = (queue_data.item.req_type == plbe_pkg::REQ_ADD) ? S_ADD0 : S_R0;
                end
            end
            S_ADD0:
            begin
                // first add on a side places the window
                if (!started_reg[sd])
                begin
                    base_next[sd] = cur_reg.half_base;
                end
                started_next[sd] = 1'b1;
                state_next       = S_ADD1;
            end
            S_ADD1:
            begin
                if (in_win)
                begin
                    idx_next   = diff[SLOT_W-1:0];
                    state_next = S_ARD;
                end
                else
                begin
                    base_next[sd] = nb;
                    idx_next      = SLOT_W'(cur_reg.item.order_price - nb);
                    state_next    = S_CLR;
                    if (shv >= SLOTS32)
                    begin
                        // full clear
                        epoch_next[sd] = epoch_reg[sd] + 1'b1;
                        best_next[sd]  = (sd == plbe_pkg::SIDE_BUY) ? '0 : TOP_SLOT;
                        clr_cnt_next   = '0;
                        clr_end_next   = TOP_SLOT;
                    end
                    else if (below)
                    begin
                        // window moves down, new low slots cleared
                        rsum = {1'b0, rot_reg[sd]} + SLOTS_EXT - {1'b0, sh};
                        if (rsum >= SLOTS_EXT)
                        begin
                            rsum = rsum - SLOTS_EXT;
                        end
                        rot_next[sd] = rsum[SLOT_W-1:0];
                        bsum = {1'b0, best_reg[sd]} + {1'b0, sh};
                        best_next[sd] = (bsum > {1'b0, TOP_SLOT}) ? TOP_SLOT : bsum[SLOT_W-1:0];
                        clr_cnt_next  = '0;
                        clr_end_next  = sh - 1'b1;
                    end
                    else
                    begin
                        // window moves up, new high slots cleared
                        rsum = {1'b0, rot_reg[sd]} + {1'b0, sh};
                        if (rsum >= SLOTS_EXT)
                        begin
                            rsum = rsum - SLOTS_EXT;
                        end
                        rot_next[sd]  = rsum[SLOT_W-1:0];
                        best_next[sd] = (best_reg[sd] >= sh) ? best_reg[sd] - sh : '0;
                        bsum          = SLOTS_EXT - {1'b0, sh};
                        clr_cnt_next  = bsum[SLOT_W-1:0];
                        clr_end_next  = TOP_SLOT;
                    end
                end
            end
            S_CLR:
            begin
                we[sd]       = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == clr_end_reg)
                begin
                    state_next = S_WRD;
                end
            end
            S_WRD:
            begin
                re[sd]     = 1'b1;
                state_next = S_WCHK;
            end
            S_WCHK:
            begin
                // step the best slot over empty levels
                if (ent.qty == '0 && sd == plbe_pkg::SIDE_BUY && best_reg[sd] != '0)
                begin
                    best_next[sd] = best_reg[sd] - 1'b1;
                    state_next    = S_WRD;
                end
                else if (ent.qty == '0 && sd == plbe_pkg::SIDE_SELL && best_reg[sd] != TOP_SLOT)
                begin
                    best_next[sd] = best_reg[sd] + 1'b1;
                    state_next    = S_WRD;
                end
                else
                begin
                    state_next = (cur_reg.item.req_type == plbe_pkg::REQ_ADD) ? S_ARD : S_ORD;
                end
            end
            S_ARD:
            begin
                re[sd]     = 1'b1;
                raddr[sd]  = to_phys(idx_reg, rot_reg[sd]);
                state_next = S_AWR;
            end
            S_AWR:
            begin
                // saturating add of shares and order count
                qsum      = {1'b0, ent.qty} + {1'b0, cur_reg.item.share_count};
                wdata.qty = qsum[32] ? plbe_pkg::QTY_MAX : qsum[31:0];
                wdata.ord = (ent.ord != plbe_pkg::ORD_MAX) ? ent.ord + 1'b1 : ent.ord;
                we[sd]    = 1'b1;
                waddr[sd] = to_phys(idx_reg, rot_reg[sd]);
                placed_next = 1'b1;
                if (sd == plbe_pkg::SIDE_BUY)
                begin
                    if (idx_reg > best_reg[sd])
                    begin
                        best_next[sd] = idx_reg;
                    end
                    state_next = S_ORD;
                end
                else
                begin
                    state_next = S_BRD;
                end
            end
            S_BRD:
            begin
                re[sd]     = 1'b1;
                state_next = S_BCHK;
            end
            S_BCHK:
            begin
                if (ent.qty == '0 || idx_reg < best_reg[sd])
                begin
                    best_next[sd] = idx_reg;
                end
                state_next = S_ORD;
            end
            S_R0:
            begin
                if (cur_reg.item.order_epoch == epoch_reg[sd] && started_reg[sd] && in_win)
                begin
                    idx_next   = diff[SLOT_W-1:0];
                    state_next = S_RRD;
                end
                else
                begin
                    state_next = S_ORD;
                end
            end
            S_RRD:
            begin
                re[sd]     = 1'b1;
                raddr[sd]  = to_phys(idx_reg, rot_reg[sd]);
                state_next = S_RWR;
            end
            S_RWR:
            begin
                // subtract shares down to zero
                wdata.qty = (ent.qty >= cur_reg.item.share_count) ?
                            ent.qty - cur_reg.item.share_count : '0;
                wdata.ord = (cur_reg.item.order_done && ent.ord != '0) ? ent.ord - 1'b1 : ent.ord;
                we[sd]    = 1'b1;
                waddr[sd] = to_phys(idx_reg, rot_reg[sd]);
                applied_next = 1'b1;
                if (cur_reg.item.order_done && idx_reg == best_reg[sd] && wdata.qty == '0)
                begin
                    state_next = S_WRD;
                end
                else
                begin
                    state_next = S_ORD;
                end
            end
            S_ORD:
            begin
                re[0]      = 1'b1;
                re[1]      = 1'b1;
                state_next = S_OCAP;
            end
            S_OCAP:
            begin
                // result goes out once the output register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    out_load                    = 1'b1;
                    rsp_next.placed             = placed_reg;
                    rsp_next.level_slot         = placed_reg ? 10'(idx_reg) : '0;
                    rsp_next.current_epoch      = epoch_reg[sd];
                    rsp_next.applied            = applied_reg;
                    rsp_next.best_buy_valid     = (qbuy != '0);
                    rsp_next.best_buy_price     = (qbuy != '0) ?
                                                  base_reg[1] + 32'(best_reg[1]) : '0;
                    rsp_next.best_buy_quantity  = qbuy;
                    rsp_next.best_sell_valid    = (qsell != '0);
                    rsp_next.best_sell_price    = (qsell != '0) ?
                                                  base_reg[0] + 32'(best_reg[0]) : '0;
                    rsp_next.best_sell_quantity = qsell;
                    state_next                  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // output register hand-off
        if (out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            base_reg[0]    <= '0;
            base_reg[1]    <= '0;
            best_reg[0]    <= '0;
            best_reg[1]    <= '0;
            rot_reg[0]     <= '0;
            rot_reg[1]     <= '0;
            started_reg[0] <= 1'b0;
            started_reg[1] <= 1'b0;
            epoch_reg[0]   <= '0;
            epoch_reg[1]   <= '0;
            clr_cnt_reg    <= '0;
            clr_end_reg    <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            best_reg      <= best_next;
            rot_reg       <= rot_next;
            started_reg   <= started_next;
            epoch_reg     <= epoch_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_end_reg   <= clr_end_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        idx_reg     <= idx_next;
        placed_reg  <= placed_next;
        applied_reg <= applied_next;
        rsp_reg     <= rsp_next;
    end

    // level memories, sell side and buy side
    plbe_level_ram #(
        .LEVEL_SLOTS (LEVEL_SLOTS),
        .SLOT_W      (SLOT_W)
    ) u_sell_ram (
        .clk   (clk),
        .we    (we[0]),
        .waddr (waddr[0]),
        .wdata (wdata),
        .re    (re[0]),
        .raddr (raddr[0]),
        .rdata (rdata[0])
    );

    plbe_level_ram #(
        .LEVEL_SLOTS (LEVEL_SLOTS),
        .SLOT_W      (SLOT_W)
    ) u_buy_ram (
        .clk   (clk),
        .we    (we[1]),
        .waddr (waddr[1]),
        .wdata (wdata),
        .re    (re[1]),
        .raddr (raddr[1]),
        .rdata (rdata[1])
    );

    // no item starts during the clearing pass
    a_no_pop_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INIT) |-> !queue_pop)
        else $error("item started during clearing pass");

    // a side memory never reads and writes in the same cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(we[0] && re[0]) && !(we[1] && re[1]))
        else $error("read and write on one side memory together");

    // ring offsets stay inside the slot range
    a_rot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rot_reg[0] <= TOP_SLOT) && (rot_reg[1] <= TOP_SLOT))
        else $error("ring offset out of range");

    // the result register is never overwritten while held
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_stall) |-> !out_load)
        else $error("held result overwritten");

endmodule

### design/price_level_book_engine.sv
// top level of the price level book engine
// result time depends on the request: a sell add runs a best-slot check that a buy add skips,
// and an applied reduce reads and writes its level while an ignored one does not
// a window shift clears each new level (up to LEVEL_SLOTS) and the best walk checks levels
// one at a time, both through the single level memory of the side
// the back sequencer finishes one item before it takes the next from the queue
// reset: asynchronous; a clearing pass over all LEVEL_SLOTS levels follows, requests stalled
module price_level_book_engine #(
    parameter int LEVEL_SLOTS = plbe_pkg::LEVEL_SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  plbe_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output plbe_pkg::rsp_item_t rsp
);

    localparam int SLOT_W = $clog2(LEVEL_SLOTS);

    logic           push;
    plbe_pkg::cmd_t push_cmd;
    logic           pop;
    plbe_pkg::cmd_t pop_cmd;
    logic           queue_full;
    logic           queue_empty;
    logic           init_busy;

    // request intake
    plbe_front #(
        .LEVEL_SLOTS (LEVEL_SLOTS)
    ) u_front (
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .queue_full (queue_full),
        .init_busy  (init_busy),
        .push       (push),
        .cmd        (push_cmd)
    );

    // decoupling queue
    plbe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .pop_data  (pop_cmd),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    // book sequencer
    plbe_back #(
        .LEVEL_SLOTS (LEVEL_SLOTS),
        .SLOT_W      (SLOT_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .queue_data  (pop_cmd),
        .queue_pop   (pop),
        .init_busy   (init_busy),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp)
    );

endmodule
